// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the bitmap field engine.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with a reset qualifier.
`define ASSERT_CLKRST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clock, disabled while reset is high.
`define ASSERT_STD(label, prop, msg) \
   `ASSERT_CLKRST(label, clock, reset, prop, msg)

`endif

// ===== rtl/bfe_pkg.sv =====
// Package of the bitmap field engine: payload structs, op codes, controller
// state and command/status types. No dependencies.
package bfe_pkg;

   localparam int MAP_BITS_DEFAULT = 4096;
   localparam int WORD_BITS        = 64;
   localparam int OP_W             = 3;
   localparam int INDEX_W          = 12;
   localparam int SIZE_W           = 13;
   localparam int CSR_AW           = 3;
   localparam int CSR_DW           = 32;

   localparam logic [SIZE_W-1:0] MAP_BITS_RESET = 13'd4096;
   localparam logic              REG_MAP_BITS   = 1'b0;

   localparam logic [OP_W-1:0] OP_GET       = 3'd0;
   localparam logic [OP_W-1:0] OP_SET       = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_ALL   = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND      = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [INDEX_W-1:0]   from_bit;
      logic [INDEX_W-1:0]   to_bit;
      logic [WORD_BITS-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] read_value;
      logic [SIZE_W-1:0]    found_index;
      logic                 ok;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_RLO,
      S_RHI,
      S_WLO,
      S_WHI,
      S_FRD,
      S_FWR,
      S_FCHK,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_CUR,
      RD_NEXT,
      RD_LAST
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_ZERO,
      WR_LO,
      WR_HI,
      WR_FILL
   } wr_sel_type;

   typedef enum logic [1:0] {
      FS_HOLD,
      FS_SIZE,
      FS_HIT
   } found_sel_type;

   typedef struct packed {
      logic          ld_req;
      logic          cnt_clr;
      logic          cnt_inc;
      logic          rd_en;
      rd_sel_type    rd_sel;
      logic          wr_en;
      wr_sel_type    wr_sel;
      logic          cap_lo;
      logic          cap_hi;
      found_sel_type found_sel;
      logic          out_ld;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            bad;
      logic            two_words;
      logic            past_size;
      logic            size_zero;
      logic            last_word;
      logic            hit;
      logic            clr_last;
   } sts_type;

endpackage

// ===== rtl/bfe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bfe_ctrl.sv =====
// Controller state machine of the bitmap field engine.
// Depends on bfe_pkg; drives the datapath by command, reads its status.
module bfe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             out_free,
   input  bfe_pkg::sts_type sts,
   output bfe_pkg::cmd_type cmd
);

   bfe_pkg::state_type state_ff;
   bfe_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfe_pkg::S_CLEAR: begin
            if (sts.clr_last) begin
               state_in = bfe_pkg::S_IDLE;
            end
         end
         bfe_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = bfe_pkg::S_DECODE;
            end
         end
         bfe_pkg::S_DECODE: begin
            if (sts.op inside {bfe_pkg::OP_GET, bfe_pkg::OP_SET}) begin
               state_in = sts.bad ? bfe_pkg::S_DONE : bfe_pkg::S_RLO;
            end else if (sts.op inside {bfe_pkg::OP_SET_ALL, bfe_pkg::OP_CLEAR_ALL}) begin
               state_in = sts.size_zero ? bfe_pkg::S_DONE : bfe_pkg::S_FRD;
            end else if (sts.op == bfe_pkg::OP_FIND) begin
               state_in = sts.past_size ? bfe_pkg::S_DONE : bfe_pkg::S_FCHK;
            end else begin
               state_in = bfe_pkg::S_DONE;
            end
         end
         bfe_pkg::S_RLO: begin
            state_in = bfe_pkg::S_RHI;
         end
         bfe_pkg::S_RHI: begin
            state_in = (sts.op == bfe_pkg::OP_SET) ? bfe_pkg::S_WLO : bfe_pkg::S_DONE;
         end
         bfe_pkg::S_WLO: begin
            state_in = sts.two_words ? bfe_pkg::S_WHI : bfe_pkg::S_DONE;
         end
         bfe_pkg::S_WHI: begin
            state_in = bfe_pkg::S_DONE;
         end
         bfe_pkg::S_FRD: begin
            state_in = bfe_pkg::S_FWR;
         end
         bfe_pkg::S_FWR: begin
            state_in = sts.last_word ? bfe_pkg::S_DONE : bfe_pkg::S_FRD;
         end
         bfe_pkg::S_FCHK: begin
            if (sts.hit || sts.last_word) begin
               state_in = bfe_pkg::S_DONE;
            end
         end
         bfe_pkg::S_DONE: begin
            if (out_free) begin
               state_in = bfe_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bfe_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.ld_req    = 1'b0;
      cmd.cnt_clr   = 1'b0;
      cmd.cnt_inc   = 1'b0;
      cmd.rd_en     = 1'b0;
      cmd.rd_sel    = bfe_pkg::RD_CUR;
      cmd.wr_en     = 1'b0;
      cmd.wr_sel    = bfe_pkg::WR_ZERO;
      cmd.cap_lo    = 1'b0;
      cmd.cap_hi    = 1'b0;
      cmd.found_sel = bfe_pkg::FS_HOLD;
      cmd.out_ld    = 1'b0;
      case (state_ff)
         bfe_pkg::S_CLEAR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = bfe_pkg::WR_ZERO;
            cmd.cnt_inc = 1'b1;
         end
         bfe_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.ld_req = req_valid;
         end
         bfe_pkg::S_DECODE: begin
            if (sts.op inside {bfe_pkg::OP_GET, bfe_pkg::OP_SET}) begin
               cmd.rd_en = !sts.bad;
            end else if (sts.op inside {bfe_pkg::OP_SET_ALL, bfe_pkg::OP_CLEAR_ALL}) begin
               cmd.cnt_clr = 1'b1;
            end else if (sts.op == bfe_pkg::OP_FIND) begin
               if (sts.past_size) begin
                  cmd.found_sel = bfe_pkg::FS_SIZE;
               end else begin
                  cmd.rd_en = 1'b1;
               end
            end
         end
         bfe_pkg::S_RLO: begin
            cmd.cap_lo = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = bfe_pkg::RD_LAST;
         end
         bfe_pkg::S_RHI: begin
            cmd.cap_hi = 1'b1;
         end
         bfe_pkg::S_WLO: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = bfe_pkg::WR_LO;
         end
         bfe_pkg::S_WHI: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = bfe_pkg::WR_HI;
         end
         bfe_pkg::S_FRD: begin
            cmd.rd_en = 1'b1;
         end
         bfe_pkg::S_FWR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = bfe_pkg::WR_FILL;
            cmd.cnt_inc = !sts.last_word;
         end
         bfe_pkg::S_FCHK: begin
            if (sts.hit) begin
               cmd.found_sel = bfe_pkg::FS_HIT;
            end else if (sts.last_word) begin
               cmd.found_sel = bfe_pkg::FS_SIZE;
            end else begin
               cmd.cnt_inc = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = bfe_pkg::RD_NEXT;
            end
         end
         bfe_pkg::S_DONE: begin
            cmd.out_ld = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfe_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/bfe_dp.sv =====
// Datapath of the bitmap field engine: word store, item registers, word
// counter, range merge/extract and first-set search. Depends on bfe_pkg, bfe_ram.
module bfe_dp #(
   parameter int MAP_BITS = bfe_pkg::MAP_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bfe_pkg::req_type            req_data,
   input  logic [bfe_pkg::SIZE_W-1:0]  map_bits,
   input  bfe_pkg::cmd_type            cmd,
   output bfe_pkg::sts_type            sts,
   output bfe_pkg::rsp_type            result
);

   localparam int WB    = bfe_pkg::WORD_BITS;
   localparam int WORDS = (MAP_BITS + WB - 1) / WB;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IW    = (WAW + 7 > 14) ? WAW + 7 : 14;

   bfe_pkg::req_type           req_ff, req_in;
   logic [WAW-1:0]             cnt_ff, cnt_in;
   logic [WB-1:0]              lo_ff, lo_in;
   logic [WB-1:0]              hi_ff, hi_in;
   logic [bfe_pkg::SIZE_W-1:0] found_ff, found_in;

   logic [WB-1:0]              rd_data;
   logic [WAW-1:0]             rd_addr;
   logic [WAW-1:0]             wr_addr;
   logic [WB-1:0]              wr_data;

   logic [IW-1:0]              s_ext, l_ext, in_s_ext, size_ext, base, rel;
   logic [WAW-1:0]             s_word, l_word, in_s_word;
   logic [bfe_pkg::SIZE_W-1:0] size_w;
   logic [bfe_pkg::INDEX_W-1:0] span;
   logic [6:0]                 n_bits;
   logic [5:0]                 off;
   logic [WB-1:0]              ones_n, fmask, lowmask, cand, onehot, extract, fill_word;
   logic [5:0]                 hit_idx;
   logic [2*WB-1:0]            cat, m128, d128, new128;
   logic                       bad;

   bfe_ram #(
      .WIDTH (WB),
      .DEPTH (WORDS)
   ) u_bfe_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s_ext     = IW'(req_ff.from_bit);
      l_ext     = IW'(req_ff.to_bit);
      in_s_ext  = IW'(req_data.from_bit);
      s_word    = s_ext[WAW+5:6];
      l_word    = l_ext[WAW+5:6];
      in_s_word = in_s_ext[WAW+5:6];
      size_w    = (32'(map_bits) > MAP_BITS) ? bfe_pkg::SIZE_W'(MAP_BITS) : map_bits;
      size_ext  = IW'(size_w);
      span      = req_ff.to_bit - req_ff.from_bit;
      n_bits    = span[6:0] + 7'd1;
      off       = req_ff.from_bit[5:0];
      bad       = (req_ff.from_bit > req_ff.to_bit) ||
                  (span > bfe_pkg::INDEX_W'(WB - 1)) ||
                  (32'(req_ff.to_bit) >= MAP_BITS);
      ones_n    = ~({WB{1'b1}} << n_bits);
      base      = IW'({cnt_ff, 6'b0});
      rel       = size_ext - base;
      fmask     = (rel >= IW'(WB)) ? {WB{1'b1}} : ~({WB{1'b1}} << rel[5:0]);
      lowmask   = (cnt_ff == s_word) ? ({WB{1'b1}} << off) : {WB{1'b1}};
      cand      = rd_data & fmask & lowmask;
      onehot    = cand & (~cand + 64'd1);
      hit_idx   = '0;
      for (int i = 0; i < WB; i++) begin
         if (onehot[i]) begin
            hit_idx = hit_idx | 6'(i);
         end
      end
      cat       = {hi_ff, lo_ff};
      m128      = {{WB{1'b0}}, ones_n} << off;
      d128      = {{WB{1'b0}}, req_ff.write_value} << off;
      new128    = (cat & ~m128) | (d128 & m128);
      extract   = WB'(cat >> off) & ones_n;
      fill_word = (req_ff.op == bfe_pkg::OP_SET_ALL) ? (rd_data | fmask) : (rd_data & ~fmask);
   end

   always_comb begin
      case (cmd.rd_sel)
         bfe_pkg::RD_CUR:  rd_addr = cnt_ff;
         bfe_pkg::RD_NEXT: rd_addr = cnt_ff + WAW'(1);
         bfe_pkg::RD_LAST: rd_addr = l_word;
         default:          rd_addr = cnt_ff;
      endcase
      case (cmd.wr_sel)
         bfe_pkg::WR_ZERO: begin
            wr_addr = cnt_ff;
            wr_data = '0;
         end
         bfe_pkg::WR_LO: begin
            wr_addr = s_word;
            wr_data = new128[WB-1:0];
         end
         bfe_pkg::WR_HI: begin
            wr_addr = l_word;
            wr_data = new128[2*WB-1:WB];
         end
         bfe_pkg::WR_FILL: begin
            wr_addr = cnt_ff;
            wr_data = fill_word;
         end
         default: begin
            wr_addr = cnt_ff;
            wr_data = '0;
         end
      endcase
   end

   always_comb begin
      req_in   = cmd.ld_req ? req_data : req_ff;
      lo_in    = cmd.cap_lo ? rd_data : lo_ff;
      hi_in    = cmd.cap_hi ? rd_data : hi_ff;
      cnt_in   = cnt_ff;
      if (cmd.ld_req) begin
         cnt_in = in_s_word;
      end else if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + WAW'(1);
      end
      case (cmd.found_sel)
         bfe_pkg::FS_SIZE: found_in = size_w;
         bfe_pkg::FS_HIT:  found_in = bfe_pkg::SIZE_W'(base | IW'(hit_idx));
         default:          found_in = found_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      found_ff <= found_in;
   end

   always_comb begin
      sts.op        = req_ff.op;
      sts.bad       = bad;
      sts.two_words = (s_word != l_word);
      sts.past_size = (s_ext >= size_ext);
      sts.size_zero = (size_w == '0);
      sts.last_word = ((base + IW'(WB)) >= size_ext);
      sts.hit       = |cand;
      sts.clr_last  = (cnt_ff == WAW'(WORDS - 1));
   end

   always_comb begin
      result.read_value  = '0;
      result.found_index = '0;
      result.ok          = 1'b0;
      if (req_ff.op inside {bfe_pkg::OP_GET, bfe_pkg::OP_SET}) begin
         result.ok = !bad;
         if (req_ff.op == bfe_pkg::OP_GET && !bad) begin
            result.read_value = extract;
         end
      end else if (req_ff.op inside {bfe_pkg::OP_SET_ALL, bfe_pkg::OP_CLEAR_ALL}) begin
         result.ok = 1'b1;
      end else if (req_ff.op == bfe_pkg::OP_FIND) begin
         result.ok          = 1'b1;
         result.found_index = found_ff;
      end
   end

endmodule

// ===== rtl/bitmap_field_engine.sv =====
// A bad range or unknown op is answered without a store access; set-all/clear-all rewrite every
// word below the map size, and find reads one word after another until a hit or the map size.
// One item at a time; the registered-read word store sets the pace.
// Reset is synchronous; a clearing pass then zeroes one store word per cycle (one per 64
// map bits) with req_ready low; configuration is taken throughout.
// Depends on bfe_pkg, bfe_ctrl, bfe_dp.
module bitmap_field_engine #(
   parameter int MAP_BITS = bfe_pkg::MAP_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bfe_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bfe_pkg::rsp_type             rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bfe_pkg::CSR_AW-1:0]   paddr,
   input  logic [bfe_pkg::CSR_DW-1:0]   pwdata,
   output logic [bfe_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);

   logic [bfe_pkg::SIZE_W-1:0] map_bits_ff, map_bits_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   bfe_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   bfe_pkg::cmd_type           cmd;
   bfe_pkg::sts_type           sts;
   bfe_pkg::rsp_type           result;
   logic                       out_free;
   logic                       csr_write;

   bfe_ctrl u_bfe_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .sts       (sts),
      .cmd       (cmd)
   );

   bfe_dp #(
      .MAP_BITS (MAP_BITS)
   ) u_bfe_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .map_bits (map_bits_ff),
      .cmd      (cmd),
      .sts      (sts),
      .result   (result)
   );

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == bfe_pkg::REG_MAP_BITS) ?
                      bfe_pkg::CSR_DW'(map_bits_ff) : '0;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      map_bits_in = map_bits_ff;
      if (csr_write && paddr[2] == bfe_pkg::REG_MAP_BITS) begin
         map_bits_in = pwdata[bfe_pkg::SIZE_W-1:0];
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_data_in = cmd.out_ld ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_bits_ff  <= bfe_pkg::MAP_BITS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_bits_ff  <= map_bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/bfe_checker.sv =====
// Port-level checker for the bitmap field engine, bound to the top level.
// Depends on bfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bfe_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bfe_pkg::rsp_type rsp_data
);

   `ASSERT_STD(a_one_item_in_flight, req_valid && req_ready |=> !req_ready, "item taken while busy")
   `ASSERT_STD(a_rsp_after_busy, $rose(rsp_valid) |-> $past(!req_ready), "result without work")
   `ASSERT_STD(a_reject_zero, rsp_valid && !rsp_data.ok |-> rsp_data.read_value == 64'd0 && rsp_data.found_index == 13'd0, "rejected item with data")
   `ASSERT_STD(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result dropped or changed")

endmodule

bind bitmap_field_engine bfe_checker u_bfe_checker (.*);

// ===== verif/bitmap_field_engine_tb.sv =====
// Self-checking testbench for bitmap_field_engine: directed and random get, set, fill, clear
// and find items over several map sizes, checked against a bit-level mirror of the store.
// Depends on bfe_pkg and the bitmap_field_engine RTL.
module bitmap_field_engine_tb;

   localparam int MAP_BITS   = bfe_pkg::MAP_BITS_DEFAULT;
   localparam int PHASES     = 10;
   localparam int PHASE_ITEMS = 100;
   localparam int LONG_HOLD  = 400;
   localparam logic [bfe_pkg::CSR_AW-1:0] MAP_BITS_ADDR = {bfe_pkg::REG_MAP_BITS, 2'b00};
   localparam logic [bfe_pkg::OP_W-1:0] OP_UNUSED = '1;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   bfe_pkg::req_type             req_data = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   bfe_pkg::rsp_type             rsp_data;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [bfe_pkg::CSR_AW-1:0]   paddr = '0;
   logic [bfe_pkg::CSR_DW-1:0]   pwdata = '0;
   logic [bfe_pkg::CSR_DW-1:0]   prdata;
   logic                         pready;

   bit idling_on = 1'b1;
   bit long_hold_due = 1'b0;

   bitmap_field_engine #(.MAP_BITS(MAP_BITS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   class bitmap_mirror;
      bit [MAP_BITS-1:0]  bits;
      int unsigned        map_size;
      bfe_pkg::rsp_type   pending_results[$];
      int unsigned        failures;
      int unsigned        checked;
      int unsigned        op_seen[8];
      int unsigned        unknown_seen;

      function new();
         bits = '0;
         map_size = bfe_pkg::MAP_BITS_RESET;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      // computes the result of one item and updates the mirrored store
      function bfe_pkg::rsp_type apply(bfe_pkg::req_type r);
         bfe_pkg::rsp_type o;
         int unsigned s, l, sz, i;
         bit bad;
         o = '0;
         s = r.from_bit;
         l = r.to_bit;
         sz = (map_size > MAP_BITS) ? MAP_BITS : map_size;
         case (r.op)
            bfe_pkg::OP_GET, bfe_pkg::OP_SET: begin
               bad = (s > l) || (l - s + 1 > bfe_pkg::WORD_BITS) || (l >= MAP_BITS);
               if (!bad) begin
                  o.ok = 1'b1;
                  for (i = s; i <= l; i++) begin
                     if (r.op == bfe_pkg::OP_GET) o.read_value[i - s] = bits[i];
                     else bits[i] = r.write_value[i - s];
                  end
               end
            end
            bfe_pkg::OP_SET_ALL, bfe_pkg::OP_CLEAR_ALL: begin
               o.ok = 1'b1;
               for (i = 0; i < sz; i++) bits[i] = (r.op == bfe_pkg::OP_SET_ALL);
            end
            bfe_pkg::OP_FIND: begin
               o.ok = 1'b1;
               o.found_index = bfe_pkg::SIZE_W'(sz);
               for (i = s; i < sz; i++) begin
                  if (bits[i]) begin
                     o.found_index = bfe_pkg::SIZE_W'(i);
                     break;
                  end
               end
            end
            default: o = '0;
         endcase
         return o;
      endfunction

      function void note_request(bfe_pkg::req_type r);
         op_seen[r.op]++;
         if (r.op > bfe_pkg::OP_FIND) unknown_seen++;
         pending_results.push_back(apply(r));
      endfunction

      function void check_result(bfe_pkg::rsp_type got);
         bfe_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result with nothing outstanding: read %h found %0d ok %b",
                        $realtime, got.read_value, got.found_index, got.ok);
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.read_value !== want.read_value || got.found_index !== want.found_index ||
             got.ok !== want.ok) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result %0d mismatch: read %h/%h found %0d/%0d ok %b/%b (exp/got)",
                        $realtime, checked, want.read_value, got.read_value,
                        want.found_index, got.found_index, want.ok, got.ok);
         end
      endfunction
   endclass

   bitmap_mirror mirror = new();

   initial begin
      forever begin
         #2 clock = ~clock;
      end
   end

   // receiver: random ready bursts plus one long hold-off
   initial begin
      int unsigned stall, hold;
      stall = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) mirror.check_result(rsp_data);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 17) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #2_400_000;
      $display("timeout with %0d results outstanding", mirror.pending());
      $display("CHECK FAILED");
      $finish;
   end

   function automatic bfe_pkg::req_type make_request(logic [bfe_pkg::OP_W-1:0] op,
                                                     int unsigned s, int unsigned l,
                                                     logic [bfe_pkg::WORD_BITS-1:0] v);
      bfe_pkg::req_type r;
      r.op = op;
      r.from_bit = bfe_pkg::INDEX_W'(s);
      r.to_bit = bfe_pkg::INDEX_W'(l);
      r.write_value = v;
      return r;
   endfunction

   function automatic bfe_pkg::req_type random_request();
      bfe_pkg::req_type r;
      int unsigned pick, width, s, l, span;
      span = (mirror.map_size == 0) ? 1 :
             ((mirror.map_size > MAP_BITS) ? MAP_BITS : mirror.map_size);
      pick = $urandom_range(0, 99);
      if (pick < 30) r.op = bfe_pkg::OP_GET;
      else if (pick < 60) r.op = bfe_pkg::OP_SET;
      else if (pick < 85) r.op = bfe_pkg::OP_FIND;
      else if (pick < 89) r.op = bfe_pkg::OP_SET_ALL;
      else if (pick < 93) r.op = bfe_pkg::OP_CLEAR_ALL;
      else r.op = bfe_pkg::OP_W'($urandom_range(bfe_pkg::OP_FIND + 1, OP_UNUSED));
      r.write_value = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) r.write_value = 64'd1 << $urandom_range(0, 63);
      s = ($urandom_range(0, 9) < 7) ? $urandom_range(0, span - 1)
                                     : $urandom_range(0, MAP_BITS - 1);
      if ($urandom_range(0, 3) == 0) s = (s & ~32'd63) + $urandom_range(48, 63);
      width = $urandom_range(1, bfe_pkg::WORD_BITS);
      if (s + width > MAP_BITS) s = MAP_BITS - width;
      l = s + width - 1;
      if ($urandom_range(0, 99) < 15) begin
         case ($urandom_range(0, 2))
            0: begin
               if (s == 0) s = $urandom_range(1, MAP_BITS - 1);
               l = $urandom_range(0, s - 1);
            end
            1: begin
               width = $urandom_range(bfe_pkg::WORD_BITS + 1, 200);
               s = $urandom_range(0, MAP_BITS - width);
               l = s + width - 1;
            end
            default: begin
               s = $urandom_range(0, MAP_BITS - 1);
               l = $urandom_range(0, MAP_BITS - 1);
            end
         endcase
      end
      r.from_bit = bfe_pkg::INDEX_W'(s);
      r.to_bit = bfe_pkg::INDEX_W'(l);
      return r;
   endfunction

   task automatic send_request(input bfe_pkg::req_type r);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mirror.note_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_map_bits(input int unsigned value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= MAP_BITS_ADDR;
      pwdata <= bfe_pkg::CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      mirror.map_size = value & 32'h1fff;
   endtask

   initial begin
      int unsigned sizes[PHASES];
      int unsigned k, n;
      sizes = '{8191, 0, 1, 63, 64, 65, 200, 4095, 0, 4096};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_map_bits(bfe_pkg::MAP_BITS_RESET);

      send_request(make_request(bfe_pkg::OP_FIND, 0, 0, '0));
      send_request(make_request(bfe_pkg::OP_GET, 0, 63, '0));
      send_request(make_request(bfe_pkg::OP_SET, 0, 63, '1));
      send_request(make_request(bfe_pkg::OP_GET, 0, 63, '0));
      send_request(make_request(bfe_pkg::OP_SET, 60, 70, 64'h5a5));
      send_request(make_request(bfe_pkg::OP_GET, 56, 119, '0));
      send_request(make_request(bfe_pkg::OP_SET, 4032, 4095, 64'hdead_beef_0123_4567));
      send_request(make_request(bfe_pkg::OP_GET, 4032, 4095, '0));
      send_request(make_request(bfe_pkg::OP_GET, 4090, 4095, '1));
      send_request(make_request(bfe_pkg::OP_GET, 0, 64, '0));
      send_request(make_request(bfe_pkg::OP_GET, 10, 9, '0));
      send_request(make_request(bfe_pkg::OP_SET, 100, 99, '1));
      send_request(make_request(bfe_pkg::OP_SET, 200, 300, '1));
      send_request(make_request(bfe_pkg::OP_FIND, 1, 4095, '0));
      send_request(make_request(bfe_pkg::OP_FIND, 64, 0, '0));
      send_request(make_request(bfe_pkg::OP_FIND, 4095, 0, '0));
      send_request(make_request(bfe_pkg::OP_SET_ALL, 4095, 4095, '1));
      send_request(make_request(bfe_pkg::OP_FIND, 100, 0, '0));
      send_request(make_request(bfe_pkg::OP_GET, 4000, 4063, '0));
      send_request(make_request(bfe_pkg::OP_CLEAR_ALL, 0, 4095, '0));
      send_request(make_request(bfe_pkg::OP_FIND, 0, 0, '0));
      send_request(make_request(OP_UNUSED, 4095, 0, '1));
      send_request(make_request(bfe_pkg::OP_SET, 4095, 4095, 64'd1));
      send_request(make_request(bfe_pkg::OP_FIND, 71, 0, '0));
      send_request(make_request(bfe_pkg::OP_GET, 4095, 4095, '0));

      for (k = 0; k < PHASES; k++) begin
         wait_drained();
         if (k == PHASES - 2) sizes[k] = $urandom_range(0, 8191);
         if (k == PHASES - 1) idling_on = 1'b0;
         write_map_bits(sizes[k]);
         if (k == 7) long_hold_due = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
      end

      req_valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d get, %0d set, %0d set-all, %0d clear-all, %0d find, %0d unknown items",
               mirror.op_seen[bfe_pkg::OP_GET], mirror.op_seen[bfe_pkg::OP_SET],
               mirror.op_seen[bfe_pkg::OP_SET_ALL], mirror.op_seen[bfe_pkg::OP_CLEAR_ALL],
               mirror.op_seen[bfe_pkg::OP_FIND], mirror.unknown_seen);
      $display("over %0d map sizes; %0d results compared, %0d failures",
               PHASES + 1, mirror.checked, mirror.failures);
      if (mirror.failures == 0 && mirror.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bfe_pkg.sv
rtl/bfe_ram.sv
rtl/bfe_ctrl.sv
rtl/bfe_dp.sv
rtl/bitmap_field_engine.sv
rtl/bfe_checker.sv
verif/bitmap_field_engine_tb.sv
